// ===== rtl/hsv_to_rgb_defines.svh =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_defines.svh
// Assertion macros for the HSV to RGB converter checker.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_DEFINES_SVH
`define HSV_TO_RGB_DEFINES_SVH

// clocked property, off during reset
`define HSV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// stalled beat keeps valid and payload
`define HSV_ASSERT_HOLD(label, vld, rdy, data) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		vld && !rdy |=> vld && $stable(data)) else $error("stalled beat changed");

`endif

// ===== rtl/hsv_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv_pkg
// Types and constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int HUE_FRACTION_BITS = 4;

	localparam int HUE_W   = 13;
	localparam int PCT_W   = 7;
	localparam int CH_W    = 8;
	localparam int PCT_MAX = 100;

	localparam int SECTOR_SIZE = 60 << HUE_FRACTION_BITS;
	localparam int FULL_TURN   = 360 << HUE_FRACTION_BITS;
	localparam int HUE_EXT_W   = ($clog2(FULL_TURN + 1) > HUE_W) ?
		$clog2(FULL_TURN + 1) : HUE_W;
	localparam int R_W         = $clog2(SECTOR_SIZE);

	// channel factors, scaled by 100 * SECTOR_SIZE
	localparam int FULL_FACTOR = PCT_MAX * SECTOR_SIZE;
	localparam int A_W         = $clog2(FULL_FACTOR + 1);

	// numerator v * factor, denominator 10000 * SECTOR_SIZE
	localparam longint NUM_MAX = longint'(PCT_MAX) * longint'(FULL_FACTOR);
	localparam int     NUM_W   = $clog2(NUM_MAX + 1);
	localparam longint DEN     = longint'(PCT_MAX * PCT_MAX) * longint'(SECTOR_SIZE);

	// round half up: (510 * num + den) / (2 * den), 2 * den = DIV << DEN_SHIFT
	localparam longint CH_SCALE  = 2 * 255;
	localparam longint N_MAX     = CH_SCALE * NUM_MAX + DEN;
	localparam int     N_W       = $clog2(N_MAX + 1);
	localparam int     DEN_SHIFT = HUE_FRACTION_BITS + 5;
	localparam longint DIV       = (2 * PCT_MAX * PCT_MAX * 60) / 32;

	// exact reciprocal divide for X_W-bit operands
	localparam longint X_MAX   = N_MAX >> DEN_SHIFT;
	localparam int     X_W     = $clog2(X_MAX + 1);
	localparam int     DIV_W   = $clog2(DIV);
	localparam int     RECIP_K = X_W + DIV_W;
	localparam longint RECIP   = ((64'd1 << RECIP_K) + DIV - 64'd1) / DIV;
	localparam int     RECIP_W = $clog2(RECIP + 1);
	localparam int     PROD_W  = X_W + RECIP_W;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t          sector;
		logic [R_W-1:0]   offset;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_sec_t;

	typedef struct packed {
		logic [A_W-1:0]   red;
		logic [A_W-1:0]   green;
		logic [A_W-1:0]   blue;
		logic [PCT_W-1:0] brightness;
	} hsv_fac_t;

endpackage

// ===== rtl/hsv_sector.sv =====
// ----------------------------------------------------------------------------
// hsv_sector
// Clamps percents, zeroes hue >= full turn, splits sector/offset. One stage.
// ----------------------------------------------------------------------------
module hsv_sector (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  hsv_pkg::hsv_t     up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output hsv_pkg::hsv_sec_t dn_data
);

	logic [hsv_pkg::HUE_EXT_W-1:0] h;
	logic [hsv_pkg::HUE_EXT_W-1:0] base;
	hsv_pkg::sector_t               sec;
	hsv_pkg::hsv_sec_t              nxt;
	logic                           valid_s1;
	hsv_pkg::hsv_sec_t              data_s1;

	always_comb begin
		h = hsv_pkg::HUE_EXT_W'(up_data.hue);
		// full turn and above wrap to zero
		if (h >= hsv_pkg::HUE_EXT_W'(hsv_pkg::FULL_TURN)) begin
			h = '0;
		end
		priority if (h >= hsv_pkg::HUE_EXT_W'(5 * hsv_pkg::SECTOR_SIZE)) begin
			sec  = hsv_pkg::SEC_MAGENTA;
			base = hsv_pkg::HUE_EXT_W'(5 * hsv_pkg::SECTOR_SIZE);
		end else if (h >= hsv_pkg::HUE_EXT_W'(4 * hsv_pkg::SECTOR_SIZE)) begin
			sec  = hsv_pkg::SEC_BLUE;
			base = hsv_pkg::HUE_EXT_W'(4 * hsv_pkg::SECTOR_SIZE);
		end else if (h >= hsv_pkg::HUE_EXT_W'(3 * hsv_pkg::SECTOR_SIZE)) begin
			sec  = hsv_pkg::SEC_CYAN;
			base = hsv_pkg::HUE_EXT_W'(3 * hsv_pkg::SECTOR_SIZE);
		end else if (h >= hsv_pkg::HUE_EXT_W'(2 * hsv_pkg::SECTOR_SIZE)) begin
			sec  = hsv_pkg::SEC_GREEN;
			base = hsv_pkg::HUE_EXT_W'(2 * hsv_pkg::SECTOR_SIZE);
		end else if (h >= hsv_pkg::HUE_EXT_W'(hsv_pkg::SECTOR_SIZE)) begin
			sec  = hsv_pkg::SEC_YELLOW;
			base = hsv_pkg::HUE_EXT_W'(hsv_pkg::SECTOR_SIZE);
		end else begin
			sec  = hsv_pkg::SEC_RED;
			base = '0;
		end
		nxt.sector = sec;
		nxt.offset = hsv_pkg::R_W'(h - base);
		nxt.saturation = (up_data.saturation > hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX)) ?
			hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX) : up_data.saturation;
		nxt.brightness = (up_data.brightness > hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX)) ?
			hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX) : up_data.brightness;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

// ===== rtl/hsv_factor.sv =====
// ----------------------------------------------------------------------------
// hsv_factor
// Forms the v, p, q and t factors and routes them to the channels. One stage.
// ----------------------------------------------------------------------------
module hsv_factor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  hsv_pkg::hsv_sec_t up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output hsv_pkg::hsv_fac_t dn_data
);

	logic [hsv_pkg::A_W-1:0] s_ext;
	logic [hsv_pkg::A_W-1:0] r_ext;
	logic [hsv_pkg::A_W-1:0] f_v;
	logic [hsv_pkg::A_W-1:0] f_p;
	logic [hsv_pkg::A_W-1:0] f_q;
	logic [hsv_pkg::A_W-1:0] f_t;
	hsv_pkg::hsv_fac_t       nxt;
	logic                    valid_s2;
	hsv_pkg::hsv_fac_t       data_s2;

	always_comb begin
		s_ext = hsv_pkg::A_W'(up_data.saturation);
		r_ext = hsv_pkg::A_W'(up_data.offset);
		f_v = hsv_pkg::A_W'(hsv_pkg::FULL_FACTOR);
		f_p = (hsv_pkg::A_W'(hsv_pkg::PCT_MAX) - s_ext) * hsv_pkg::A_W'(hsv_pkg::SECTOR_SIZE);
		f_q = f_v - s_ext * r_ext;
		f_t = f_v - s_ext * (hsv_pkg::A_W'(hsv_pkg::SECTOR_SIZE) - r_ext);
		nxt.brightness = up_data.brightness;
		unique case (up_data.sector)
			hsv_pkg::SEC_RED: begin
				nxt.red = f_v; nxt.green = f_t; nxt.blue = f_p;
			end
			hsv_pkg::SEC_YELLOW: begin
				nxt.red = f_q; nxt.green = f_v; nxt.blue = f_p;
			end
			hsv_pkg::SEC_GREEN: begin
				nxt.red = f_p; nxt.green = f_v; nxt.blue = f_t;
			end
			hsv_pkg::SEC_CYAN: begin
				nxt.red = f_p; nxt.green = f_q; nxt.blue = f_v;
			end
			hsv_pkg::SEC_BLUE: begin
				nxt.red = f_t; nxt.green = f_p; nxt.blue = f_v;
			end
			hsv_pkg::SEC_MAGENTA: begin
				nxt.red = f_v; nxt.green = f_p; nxt.blue = f_q;
			end
			default: begin
				nxt.red = f_v; nxt.green = f_p; nxt.blue = f_q;
			end
		endcase
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s2 <= nxt;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule

// ===== rtl/hsv_round.sv =====
// ----------------------------------------------------------------------------
// hsv_round
// Scales each factor by v and rounds to 8 bits with a reciprocal divide.
// Three stages: product, rounding numerator, reciprocal multiply.
// ----------------------------------------------------------------------------
module hsv_round (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  hsv_pkg::hsv_fac_t up_data,
	output logic              dn_valid,
	input  logic              dn_ready,
	output hsv_pkg::rgb_t     dn_data
);

	logic [2:0][hsv_pkg::A_W-1:0]    fac;
	logic [2:0][hsv_pkg::NUM_W-1:0]  num_nxt;
	logic [2:0][hsv_pkg::X_W-1:0]    x_nxt;
	logic [2:0][hsv_pkg::PROD_W-1:0] prod;
	logic [2:0][hsv_pkg::CH_W-1:0]   ch_nxt;
	logic [hsv_pkg::N_W-1:0]         n_tmp;

	logic                            valid_s3;
	logic                            valid_s4;
	logic                            valid_s5;
	logic [2:0][hsv_pkg::NUM_W-1:0]  num_s3;
	logic [2:0][hsv_pkg::X_W-1:0]    x_s4;
	logic [2:0][hsv_pkg::CH_W-1:0]   ch_s5;
	logic                            en_s3;
	logic                            en_s4;
	logic                            en_s5;

	assign fac[0] = up_data.red;
	assign fac[1] = up_data.green;
	assign fac[2] = up_data.blue;

	always_comb begin
		n_tmp = '0;
		for (int c = 0; c < 3; c++) begin
			num_nxt[c] = hsv_pkg::NUM_W'(up_data.brightness) * hsv_pkg::NUM_W'(fac[c]);
			n_tmp = hsv_pkg::N_W'(num_s3[c]) * hsv_pkg::N_W'(hsv_pkg::CH_SCALE)
				+ hsv_pkg::N_W'(hsv_pkg::DEN);
			x_nxt[c] = hsv_pkg::X_W'(n_tmp >> hsv_pkg::DEN_SHIFT);
			prod[c] = hsv_pkg::PROD_W'(x_s4[c]) * hsv_pkg::PROD_W'(hsv_pkg::RECIP);
			ch_nxt[c] = prod[c][hsv_pkg::RECIP_K +: hsv_pkg::CH_W];
		end
	end

	assign en_s5    = !valid_s5 || dn_ready;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign up_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= up_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && up_valid) begin
			num_s3 <= num_nxt;
		end
		if (en_s4 && valid_s3) begin
			x_s4 <= x_nxt;
		end
		if (en_s5 && valid_s4) begin
			ch_s5 <= ch_nxt;
		end
	end

	assign dn_valid      = valid_s5;
	assign dn_data.red   = ch_s5[0];
	assign dn_data.green = ch_s5[1];
	assign dn_data.blue  = ch_s5[2];

endmodule

// ===== rtl/hsv_to_rgb.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb
// HSV to 8-bit RGB converter, five register stages.
// Throughput: one beat per cycle while the output is not stalled; each stage
// holds one beat and takes a new one as soon as it empties, so a stalled
// output only fills the pipeline.
// Reset: arst_n clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsv_valid,
	output logic          hsv_ready,
	input  hsv_pkg::hsv_t hsv,
	output logic          rgb_valid,
	input  logic          rgb_ready,
	output hsv_pkg::rgb_t rgb
);

	logic              sec_valid;
	logic              sec_ready;
	hsv_pkg::hsv_sec_t sec_data;
	logic              fac_valid;
	logic              fac_ready;
	hsv_pkg::hsv_fac_t fac_data;

	hsv_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (hsv_valid),
		.up_ready (hsv_ready),
		.up_data  (hsv),
		.dn_valid (sec_valid),
		.dn_ready (sec_ready),
		.dn_data  (sec_data)
	);

	hsv_factor u_factor (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sec_valid),
		.up_ready (sec_ready),
		.up_data  (sec_data),
		.dn_valid (fac_valid),
		.dn_ready (fac_ready),
		.dn_data  (fac_data)
	);

	hsv_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fac_valid),
		.up_ready (fac_ready),
		.up_data  (fac_data),
		.dn_valid (rgb_valid),
		.dn_ready (rgb_ready),
		.dn_data  (rgb)
	);

endmodule

// ===== rtl/hsv_check.sv =====
// ----------------------------------------------------------------------------
// hsv_check
// Port-level checks of the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_defines.svh"

module hsv_check (
	input logic          clk,
	input logic          arst_n,
	input logic          hsv_valid,
	input logic          hsv_ready,
	input hsv_pkg::hsv_t hsv,
	input logic          rgb_valid,
	input logic          rgb_ready,
	input hsv_pkg::rgb_t rgb
);

	logic hsv_beat;
	logic black_beat;
	logic rgb_black;

	assign hsv_beat   = hsv_valid && hsv_ready;
	assign black_beat = hsv_beat && hsv.brightness == '0;
	assign rgb_black  = rgb.red == '0 && rgb.green == '0 && rgb.blue == '0;

	`HSV_ASSERT(a_ready_when_drained, !rgb_valid |-> hsv_ready, "input stalled with empty output")

	`HSV_ASSERT_HOLD(a_rgb_hold, rgb_valid, rgb_ready, rgb)

	`HSV_ASSERT(a_latency, hsv_beat ##1 rgb_ready[*4] |=> rgb_valid, "result late")

	`HSV_ASSERT(a_black, black_beat ##1 rgb_ready[*4] |=> rgb_black, "zero brightness not black")

endmodule

bind hsv_to_rgb hsv_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.hsv_valid (hsv_valid),
	.hsv_ready (hsv_ready),
	.hsv       (hsv),
	.rgb_valid (rgb_valid),
	.rgb_ready (rgb_ready),
	.rgb       (rgb)
);

// ===== tb/hsv_to_rgb_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_test
// Self-checking bench for the HSV to RGB converter. Directed corner colors,
// then random colors under several mixes of input gaps and output stalls,
// plus one long output hold-off that backs the pipeline up. Every beat is
// checked channel by channel against an exact rational conversion.
// ----------------------------------------------------------------------------
module hsv_to_rgb_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic           clk;
	logic           arst_n;
	logic           hsv_valid;
	logic           hsv_ready;
	hsv_pkg::hsv_t  hsv;
	logic           rgb_valid;
	logic           rgb_ready;
	hsv_pkg::rgb_t  rgb;

	hsv_pkg::hsv_t  hsv_pending[$];
	hsv_pkg::rgb_t  rgb_expected[$];
	int    items_queued = 0;
	int    hsv_offered = 0;
	int    hsv_beats = 0;
	int    rgb_beats = 0;
	int    mismatches = 0;
	int    unexpected = 0;
	int    cycles = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	int    hold_cycles = 0;
	logic  hold_start = 1'b0;

	hsv_to_rgb u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.hsv_valid (hsv_valid),
		.hsv_ready (hsv_ready),
		.hsv       (hsv),
		.rgb_valid (rgb_valid),
		.rgb_ready (rgb_ready),
		.rgb       (rgb)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// round(255 * num / den), half up
	function automatic logic [hsv_pkg::CH_W-1:0] scale_channel(longint unsigned num,
			longint unsigned den);
		return hsv_pkg::CH_W'((2 * 255 * num + den) / (2 * den));
	endfunction

	function automatic hsv_pkg::rgb_t convert_hsv(hsv_pkg::hsv_t c);
		longint unsigned h, s, v, d, den, off, vn, pn, qn, tn, rn, gn, bn;
		hsv_pkg::sector_t sec;
		hsv_pkg::rgb_t res;
		d = hsv_pkg::SECTOR_SIZE;
		den = 10000 * d;
		h = c.hue;
		s = c.saturation;
		v = c.brightness;
		if (h > hsv_pkg::FULL_TURN) h = hsv_pkg::FULL_TURN;
		if (h == hsv_pkg::FULL_TURN) h = 0;
		if (s > hsv_pkg::PCT_MAX) s = hsv_pkg::PCT_MAX;
		if (v > hsv_pkg::PCT_MAX) v = hsv_pkg::PCT_MAX;
		sec = hsv_pkg::sector_t'(h / d);
		off = h % d;
		vn = v * hsv_pkg::PCT_MAX * d;
		pn = v * (hsv_pkg::PCT_MAX - s) * d;
		qn = v * (hsv_pkg::PCT_MAX * d - s * off);
		tn = v * (hsv_pkg::PCT_MAX * d - s * (d - off));
		case (sec)
			hsv_pkg::SEC_RED: begin
				rn = vn; gn = tn; bn = pn;
			end
			hsv_pkg::SEC_YELLOW: begin
				rn = qn; gn = vn; bn = pn;
			end
			hsv_pkg::SEC_GREEN: begin
				rn = pn; gn = vn; bn = tn;
			end
			hsv_pkg::SEC_CYAN: begin
				rn = pn; gn = qn; bn = vn;
			end
			hsv_pkg::SEC_BLUE: begin
				rn = tn; gn = pn; bn = vn;
			end
			default: begin
				rn = vn; gn = pn; bn = qn;
			end
		endcase
		res.red = scale_channel(rn, den);
		res.green = scale_channel(gn, den);
		res.blue = scale_channel(bn, den);
		return res;
	endfunction

	function automatic logic [hsv_pkg::PCT_W-1:0] random_pct();
		case ($urandom_range(9))
			0: return '0;
			1: return hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX);
			2, 3: return hsv_pkg::PCT_W'($urandom_range(127));
			default: return hsv_pkg::PCT_W'($urandom_range(hsv_pkg::PCT_MAX));
		endcase
	endfunction

	task automatic queue_hsv(input hsv_pkg::hsv_t c);
		hsv_pending.push_back(c);
		items_queued++;
	endtask

	task automatic queue_random(input int count);
		hsv_pkg::hsv_t c;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: c.hue = hsv_pkg::HUE_W'($urandom_range(8191));
				1: c.hue = hsv_pkg::HUE_W'(hsv_pkg::FULL_TURN);
				2, 3: c.hue = hsv_pkg::HUE_W'($urandom_range(6) * hsv_pkg::SECTOR_SIZE
					+ $urandom_range(2) - 1);
				default: c.hue = hsv_pkg::HUE_W'($urandom_range(hsv_pkg::FULL_TURN - 1));
			endcase
			c.saturation = random_pct();
			c.brightness = random_pct();
			queue_hsv(c);
		end
	endtask

	task automatic drain();
		while (hsv_beats != items_queued || rgb_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		queue_random(count);
		drain();
	endtask

	// sender
	always @(negedge clk) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
		end else if (hsv_beats == hsv_offered) begin
			if (hsv_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				hsv <= hsv_pending.pop_front();
				hsv_valid <= 1'b1;
				hsv_offered++;
			end else begin
				hsv_valid <= 1'b0;
			end
		end
	end

	// receiver, with a counted hold-off once started
	always @(negedge clk) begin
		if (!arst_n) begin
			rgb_ready <= 1'b0;
		end else if (hold_start && hold_cycles < HOLD_CYCLES) begin
			rgb_ready <= 1'b0;
			hold_cycles++;
		end else begin
			rgb_ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// beat monitor and checker
	always @(posedge clk) begin
		hsv_pkg::rgb_t want;
		if (arst_n) begin
			if (hsv_valid && hsv_ready) begin
				rgb_expected.push_back(convert_hsv(hsv));
				hsv_beats++;
			end
			if (rgb_valid && rgb_ready) begin
				rgb_beats++;
				if (rgb_expected.size() == 0) begin
					unexpected++;
					$display("unexpected rgb beat r=%0d g=%0d b=%0d",
						rgb.red, rgb.green, rgb.blue);
				end else begin
					want = rgb_expected.pop_front();
					if (rgb.red !== want.red || rgb.green !== want.green ||
							rgb.blue !== want.blue) begin
						if (mismatches < 10)
							$display({"rgb beat %0d: expected r=%0d g=%0d b=%0d,",
								" got r=%0d g=%0d b=%0d"},
								rgb_beats, want.red, want.green, want.blue,
								rgb.red, rgb.green, rgb.blue);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding",
				cycles, rgb_expected.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int fails;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sector starts and edges, a sector center, wrap, saturation limits, grey
		queue_hsv('{13'd0, 7'd100, 7'd100});
		queue_hsv('{13'd960, 7'd100, 7'd100});
		queue_hsv('{13'd1920, 7'd100, 7'd100});
		queue_hsv('{13'd2880, 7'd100, 7'd100});
		queue_hsv('{13'd3840, 7'd100, 7'd100});
		queue_hsv('{13'd4800, 7'd100, 7'd100});
		queue_hsv('{13'd480, 7'd100, 7'd100});
		queue_hsv('{13'd5759, 7'd100, 7'd100});
		queue_hsv('{13'd5760, 7'd100, 7'd100});
		queue_hsv('{13'd5761, 7'd100, 7'd100});
		queue_hsv('{13'd8191, 7'd127, 7'd127});
		queue_hsv('{13'd1234, 7'd0, 7'd50});
		queue_hsv('{13'd0, 7'd0, 7'd100});
		queue_hsv('{13'd0, 7'd0, 7'd0});
		queue_hsv('{13'd2000, 7'd127, 7'd127});
		queue_hsv('{13'd3000, 7'd50, 7'd0});
		queue_hsv('{13'd4000, 7'd100, 7'd1});
		queue_hsv('{13'd959, 7'd1, 7'd99});
		queue_hsv('{13'd961, 7'd99, 7'd1});
		queue_hsv('{13'd4321, 7'd100, 7'd127});
		queue_hsv('{13'd8191, 7'd0, 7'd0});
		queue_hsv('{13'd5000, 7'd37, 7'd63});
		drain();

		run_phase(0, 0, 230);
		run_phase(60, 0, 230);
		run_phase(0, 60, 230);
		run_phase(7, 7, 230);

		// long output hold-off while the sender keeps pushing
		send_idle_pct = 0;
		recv_stall_pct = 0;
		queue_random(40);
		hold_start = 1'b1;
		wait (hold_cycles == HOLD_CYCLES);
		drain();

		repeat (20) @(posedge clk);
		fails = mismatches + unexpected + rgb_expected.size();
		$display("%0d colors converted: corner hues and percents, four gap/stall mixes,",
			hsv_beats);
		$display("one %0d-cycle output hold-off; %0d mismatches, %0d unexpected beats",
			HOLD_CYCLES, mismatches, unexpected);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hsv_pkg.sv
rtl/hsv_sector.sv
rtl/hsv_factor.sv
rtl/hsv_round.sv
rtl/hsv_to_rgb.sv
rtl/hsv_check.sv
tb/hsv_to_rgb_test.sv
